[src/gha_pkg.sv]
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int GEN_W      = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int PTR_W      = IDX_W + 1;
  localparam int CNT_W      = PTR_W;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int PADDR_W    = 3;

  localparam logic [PTR_W-1:0] NULL_PTR       = PTR_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] SLOT_LIMIT_RST = CNT_W'(1024);
  localparam logic [GEN_W-1:0] GEN_LIMIT_RST  = GEN_W'(65535);

  localparam logic [1:0] CMD_CREATE   = 2'd0;
  localparam logic [1:0] CMD_DESTROY  = 2'd1;
  localparam logic [1:0] CMD_CONTAINS = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NOT_LIVE = 2'd1;
  localparam logic [1:0] STS_LIMIT    = 2'd2;

  localparam logic REG_SLOT_LIMIT = 1'b0;
  localparam logic REG_GEN_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    OP_CREATE,
    OP_DESTROY,
    OP_CONTAINS,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_CLR_RD,
    BK_CLR_WR
  } bk_state_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] handle_index;
    logic [GEN_W-1:0] handle_generation;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] new_index;
    logic [GEN_W-1:0] new_generation;
    logic [CNT_W-1:0] live_count;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } q_entry_t;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic             occ;
    logic             ret;
    logic [PTR_W-1:0] next;
  } slot_t;

  typedef struct packed {
    logic [CNT_W-1:0] slot_limit;
    logic [GEN_W-1:0] gen_limit;
  } cfg_t;

endpackage

[src/gha_front.sv]
// ----------------------------------------------------------------------------
// gha_front
// Accepts command beats, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module gha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gha_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output gha_pkg::q_entry_t q_data
);
  import gha_pkg::*;

  q_entry_t             entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  q_entry_t             dec;
  logic                 push, pop;

  always_comb begin
    dec.idx = in_data.handle_index;
    dec.gen = in_data.handle_generation;
    case (in_data.command)
      CMD_CREATE:   dec.op = OP_CREATE;
      CMD_DESTROY:  dec.op = OP_DESTROY;
      CMD_CONTAINS: dec.op = OP_CONTAINS;
      CMD_CLEAR:    dec.op = OP_CLEAR;
      default:      dec.op = OP_CLEAR;
    endcase
  end

  assign in_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_data   = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

[src/gha_back.sv]
// ----------------------------------------------------------------------------
// gha_back
// Slot table, free list and sequencer; executes one command at a time and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module gha_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gha_pkg::cfg_t      cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  gha_pkg::q_entry_t  q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gha_pkg::out_item_t out_data
);
  import gha_pkg::*;

  slot_t              mem [SLOT_COUNT];
  slot_t              rdata_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;
  slot_t              mem_wdata;

  bk_state_t          state_r, state_nxt;
  q_entry_t           cmd_r, cmd_nxt;
  logic               idx_ok_r, idx_ok_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [PTR_W-1:0]   clr_r, clr_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               out_free, pop;
  logic [CNT_W-1:0]   lim;
  logic               live, at_limit, ret_new;

  assign out_free  = !out_valid_r || out_ready;
  assign q_ready   = (state_r == BK_IDLE) && out_free;
  assign pop       = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign lim       = (cfg.slot_limit > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                           : cfg.slot_limit;
  assign live      = idx_ok_r && rdata_r.occ && (rdata_r.gen == cmd_r.gen);
  assign at_limit  = (rdata_r.gen == cfg.gen_limit);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_ok_nxt    = idx_ok_r;
    head_nxt      = head_r;
    used_nxt      = used_r;
    occ_nxt       = occ_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    ret_new       = 1'b0;

    case (state_r)
      BK_IDLE: begin
        mem_raddr = (q_data.op == OP_CREATE) ? head_r[IDX_W-1:0] : q_data.idx;
        if (pop) begin
          cmd_nxt    = q_data;
          idx_ok_nxt = ({1'b0, q_data.idx} < used_r);
          if (q_data.op == OP_CLEAR) begin
            head_nxt  = NULL_PTR;
            clr_nxt   = '0;
            state_nxt = BK_CLR_RD;
          end else begin
            state_nxt = BK_EXEC;
          end
        end
      end

      BK_EXEC: begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = '0;
        out_data_nxt.status = STS_OK;
        state_nxt      = BK_IDLE;
        case (cmd_r.op)
          OP_CREATE: begin
            if (head_r != NULL_PTR) begin
              mem_we     = 1'b1;
              mem_waddr  = head_r[IDX_W-1:0];
              mem_wdata  = rdata_r;
              mem_wdata.occ  = 1'b1;
              mem_wdata.next = NULL_PTR;
              head_nxt   = rdata_r.next;
              occ_nxt    = occ_r + 1'b1;
              out_data_nxt.new_index      = head_r[IDX_W-1:0];
              out_data_nxt.new_generation = rdata_r.gen;
            end else if (used_r < lim) begin
              mem_we     = 1'b1;
              mem_waddr  = used_r[IDX_W-1:0];
              mem_wdata.gen  = '0;
              mem_wdata.occ  = 1'b1;
              mem_wdata.ret  = 1'b0;
              mem_wdata.next = NULL_PTR;
              used_nxt   = used_r + 1'b1;
              occ_nxt    = occ_r + 1'b1;
              out_data_nxt.new_index = used_r[IDX_W-1:0];
            end else begin
              out_data_nxt.status = STS_LIMIT;
            end
          end
          OP_DESTROY: begin
            if (live) begin
              ret_new    = rdata_r.ret || at_limit;
              mem_we     = 1'b1;
              mem_waddr  = cmd_r.idx;
              mem_wdata.gen  = at_limit ? rdata_r.gen : GEN_W'(rdata_r.gen + 1'b1);
              mem_wdata.occ  = 1'b0;
              mem_wdata.ret  = ret_new;
              mem_wdata.next = ret_new ? NULL_PTR : head_r;
              if (!ret_new) begin
                head_nxt = {1'b0, cmd_r.idx};
              end
              occ_nxt    = occ_r - 1'b1;
            end else begin
              out_data_nxt.status = STS_NOT_LIVE;
            end
          end
          OP_CONTAINS: begin
            out_data_nxt.status = live ? STS_OK : STS_NOT_LIVE;
          end
          default: begin
            out_data_nxt.status = STS_OK;
          end
        endcase
        out_data_nxt.live_count = occ_nxt;
      end

      BK_CLR_RD: begin
        mem_raddr = clr_r[IDX_W-1:0];
        if (clr_r == used_r) begin
          occ_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.status = STS_OK;
          state_nxt     = BK_IDLE;
        end else begin
          state_nxt = BK_CLR_WR;
        end
      end

      BK_CLR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[IDX_W-1:0];
        mem_wdata = rdata_r;
        if (rdata_r.occ) begin
          ret_new       = rdata_r.ret || at_limit;
          mem_wdata.occ = 1'b0;
          mem_wdata.gen = at_limit ? rdata_r.gen : GEN_W'(rdata_r.gen + 1'b1);
        end else begin
          ret_new = rdata_r.ret;
        end
        mem_wdata.ret  = ret_new;
        mem_wdata.next = ret_new ? NULL_PTR : head_r;
        if (!ret_new) begin
          head_nxt = clr_r;
        end
        clr_nxt   = clr_r + 1'b1;
        state_nxt = BK_CLR_RD;
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= NULL_PTR;
      used_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_ok_r   <= idx_ok_nxt;
    clr_r      <= clr_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

`ifndef ASSERT_OFF
  a_occ_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= used_r)
    else $error("live count exceeds used slots");
  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(SLOT_COUNT))
    else $error("used slots exceed capacity");
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE) |-> (head_r == NULL_PTR || head_r < used_r))
    else $error("free list head outside used slots");
  a_pop_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EXEC) |-> !out_valid_r)
    else $error("result register busy at execute");
`endif

endmodule

[src/generational_handle_allocator_unit.sv]
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Generational handle allocator: slot table with LIFO free list.
// ----------------------------------------------------------------------------
// Create, destroy and contains each do a read of the slot table in the back
// end, then its write-back (contains writes nothing); the back end takes a
// new command only once it is idle and its result register is free. Clear
// walks every slot ever used, one table read and one write per slot. A
// 2-beat command queue keeps the input open while the back end is busy or a
// result waits. Registers: slot_limit at 0x0, generation_limit at 0x4;
// write only while idle.
module generational_handle_allocator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gha_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gha_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gha_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import gha_pkg::*;

  cfg_t      cfg_r;
  logic      wr_en;
  logic      q_valid, q_ready;
  q_entry_t  q_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_limit <= SLOT_LIMIT_RST;
      cfg_r.gen_limit  <= GEN_LIMIT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SLOT_LIMIT: cfg_r.slot_limit <= pwdata[CNT_W-1:0];
        REG_GEN_LIMIT:  cfg_r.gen_limit  <= pwdata[GEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLOT_LIMIT: prdata = 32'(cfg_r.slot_limit);
      REG_GEN_LIMIT:  prdata = 32'(cfg_r.gen_limit);
      default:        prdata = '0;
    endcase
  end

  gha_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  gha_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the generational handle allocator. A handle-table
// ledger tracks slots, generations and the free list, predicts every reply
// and matches the replies in order. Directed corner sequences come first:
// the slot limit, retiring slots, stale handles and clear. Randomized phases
// with different limits follow, with random gaps and stalls on both
// channels and long output hold-offs.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gha_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_SLOT_LIMIT = {REG_SLOT_LIMIT, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_GEN_LIMIT  = {REG_GEN_LIMIT, 2'b00};

  class handle_ledger;
    logic [GEN_W-1:0] gen_tbl [SLOT_COUNT];
    bit               occ_tbl [SLOT_COUNT];
    bit               ret_tbl [SLOT_COUNT];
    int               next_tbl [SLOT_COUNT];
    int               free_head;
    int               used;
    int               live;
    int               slot_limit;
    logic [GEN_W-1:0] gen_limit;
    out_item_t        replies_due[$];
    int               errors;

    function new();
      free_head  = SLOT_COUNT;
      used       = 0;
      live       = 0;
      slot_limit = SLOT_LIMIT_RST;
      gen_limit  = GEN_LIMIT_RST;
      errors     = 0;
    endfunction

    function void set_register(bit is_gen, logic [31:0] v);
      if (is_gen) begin
        gen_limit = v[GEN_W-1:0];
      end else begin
        slot_limit = v[CNT_W-1:0];
      end
    endfunction

    function bit is_live(int idx, logic [GEN_W-1:0] g);
      return idx < used && occ_tbl[idx] && gen_tbl[idx] == g;
    endfunction

    function void vacate(int idx);
      occ_tbl[idx] = 1'b0;
      if (gen_tbl[idx] == gen_limit) begin
        ret_tbl[idx] = 1'b1;
      end else begin
        gen_tbl[idx] = gen_tbl[idx] + 1'b1;
      end
    endfunction

    function void log_command(in_item_t it);
      out_item_t exp;
      int        h;
      int        lim;
      int        idx;
      exp = '0;
      exp.status = STS_OK;
      idx = int'(it.handle_index);
      case (it.command)
        CMD_CREATE: begin
          if (free_head < SLOT_COUNT) begin
            h = free_head;
            exp.new_index      = IDX_W'(h);
            exp.new_generation = gen_tbl[h];
            occ_tbl[h]  = 1'b1;
            free_head   = next_tbl[h];
            next_tbl[h] = SLOT_COUNT;
            live++;
          end else begin
            lim = (slot_limit < SLOT_COUNT) ? slot_limit : SLOT_COUNT;
            if (used < lim) begin
              gen_tbl[used]  = '0;
              next_tbl[used] = SLOT_COUNT;
              occ_tbl[used]  = 1'b1;
              ret_tbl[used]  = 1'b0;
              exp.new_index  = IDX_W'(used);
              used++;
              live++;
            end else begin
              exp.status = STS_LIMIT;
            end
          end
        end
        CMD_DESTROY: begin
          if (is_live(idx, it.handle_generation)) begin
            vacate(idx);
            if (ret_tbl[idx]) begin
              next_tbl[idx] = SLOT_COUNT;
            end else begin
              next_tbl[idx] = free_head;
              free_head     = idx;
            end
            live--;
          end else begin
            exp.status = STS_NOT_LIVE;
          end
        end
        CMD_CONTAINS: begin
          exp.status = is_live(idx, it.handle_generation) ? STS_OK : STS_NOT_LIVE;
        end
        default: begin
          free_head = SLOT_COUNT;
          for (int i = 0; i < used; i++) begin
            if (occ_tbl[i]) vacate(i);
            next_tbl[i] = SLOT_COUNT;
            if (!ret_tbl[i]) begin
              next_tbl[i] = free_head;
              free_head   = i;
            end
          end
          live = 0;
        end
      endcase
      exp.live_count = CNT_W'(live);
      replies_due.insert(replies_due.size(), exp);
    endfunction

    function void match_reply(out_item_t got);
      out_item_t exp;
      if (replies_due.size() == 0) begin
        $display("%0t unexpected reply: actual %h", $time, got);
        errors++;
        return;
      end
      exp = replies_due.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t status: expected %0d, actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.new_index !== exp.new_index) begin
        $display("%0t new_index: expected %0d, actual %0d",
                 $time, exp.new_index, got.new_index);
        errors++;
      end
      if (got.new_generation !== exp.new_generation) begin
        $display("%0t new_generation: expected %0d, actual %0d",
                 $time, exp.new_generation, got.new_generation);
        errors++;
      end
      if (got.live_count !== exp.live_count) begin
        $display("%0t live_count: expected %0d, actual %0d",
                 $time, exp.live_count, got.live_count);
        errors++;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  handle_ledger ledger;
  int           beats_seen = 0;
  bit           tx_calm    = 1'b0;

  generational_handle_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  initial begin
    #(40_000_000);
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, calm stretches, long hold-offs
  initial begin
    int  stall_left;
    int  hold_left;
    bit  calm;
    bit  rdy;
    stall_left = 0;
    hold_left  = 0;
    calm       = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(99, 0) == 0) calm = !calm;
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if (calm || $urandom_range(99, 0) < 70) begin
        rdy = 1'b1;
      end else begin
        rdy = 1'b0;
        stall_left = ($urandom_range(19, 0) == 0) ? $urandom_range(60, 20)
                                                   : $urandom_range(2, 0);
      end
      out_ready <= rdy;
      @(posedge clk);
      if (out_valid && out_ready) begin
        ledger.match_reply(out_data);
        beats_seen++;
        if (beats_seen == 300 || beats_seen == 1000) hold_left = 300;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if ($urandom_range(49, 0) == 0) tx_calm = !tx_calm;
    if (tx_calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(50, 10);
  endfunction

  function automatic in_item_t cmd(logic [1:0] c, int idx, logic [GEN_W-1:0] g);
    in_item_t it;
    it.command           = c;
    it.handle_index      = IDX_W'(idx);
    it.handle_generation = g;
    return it;
  endfunction

  function automatic in_item_t make_command(int pc, int pd, int pq);
    in_item_t it;
    int       r;
    int       idx;
    it.handle_index      = IDX_W'($urandom);
    it.handle_generation = GEN_W'($urandom);
    r = $urandom_range(99, 0);
    if (r < pc || ledger.used == 0) begin
      it.command = CMD_CREATE;
      return it;
    end
    if (r >= pc + pd + pq) begin
      it.command = CMD_CLEAR;
      return it;
    end
    it.command = (r < pc + pd) ? CMD_DESTROY : CMD_CONTAINS;
    idx = $urandom_range(ledger.used - 1, 0);
    repeat (4) if (!ledger.occ_tbl[idx]) idx = $urandom_range(ledger.used - 1, 0);
    it.handle_index = IDX_W'(idx);
    case ($urandom_range(9, 0))
      7: it.handle_generation = ledger.gen_tbl[idx] - 1'b1;
      8, 9: ;
      default: it.handle_generation = ledger.gen_tbl[idx];
    endcase
    return it;
  endfunction

  task automatic send_command(input in_item_t it, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.log_command(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] val,
                           input logic [31:0] mask);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ledger.set_register(addr == ADDR_GEN_LIMIT, val);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== (val & mask)) begin
      $display("%0t readback @%0d: expected %h, actual %h", $time, addr, val & mask, prdata);
      ledger.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limits(input int slots, input int gens);
    drain();
    write_reg(ADDR_SLOT_LIMIT, slots, 32'h7FF);
    write_reg(ADDR_GEN_LIMIT, gens, 32'hFFFF);
  endtask

  task automatic run_phase(input int n, input int pc, input int pd, input int pq);
    repeat (n) send_command(make_command(pc, pd, pq), pick_gap());
  endtask

  initial begin
    in_item_t warmup[$];
    in_item_t tail[$];
    ledger = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // limit of three slots, retire at generation one
    set_limits(3, 1);
    warmup = '{cmd(CMD_CREATE, 1023, 16'hFFFF), cmd(CMD_CREATE, 0, 0),
               cmd(CMD_CREATE, 512, 16'h8000), cmd(CMD_CREATE, 0, 0),
               cmd(CMD_CONTAINS, 1, 0), cmd(CMD_CONTAINS, 1, 16'hFFFF),
               cmd(CMD_DESTROY, 0, 0), cmd(CMD_DESTROY, 0, 0),
               cmd(CMD_CREATE, 0, 0), cmd(CMD_DESTROY, 0, 1),
               cmd(CMD_CONTAINS, 0, 1), cmd(CMD_CREATE, 0, 0),
               cmd(CMD_DESTROY, 2, 0), cmd(CMD_CLEAR, 1023, 16'hFFFF),
               cmd(CMD_CREATE, 0, 0), cmd(CMD_CREATE, 0, 0),
               cmd(CMD_CREATE, 0, 0)};
    foreach (warmup[i]) send_command(warmup[i], pick_gap());

    // zero limits: no appends, a lowered generation limit already passed
    set_limits(0, 0);
    tail = '{cmd(CMD_DESTROY, 1, 1), cmd(CMD_CREATE, 0, 0), cmd(CMD_CREATE, 0, 0),
             cmd(CMD_DESTROY, 2, 1), cmd(CMD_CLEAR, 0, 0), cmd(CMD_CONTAINS, 1, 3),
             cmd(CMD_CREATE, 0, 0), cmd(CMD_CREATE, 0, 0)};
    foreach (tail[i]) send_command(tail[i], pick_gap());

    set_limits(8, 3);
    run_phase(200, 40, 35, 20);
    set_limits(64, 65535);
    run_phase(200, 40, 35, 20);
    set_limits(1024, 1);
    run_phase(700, 92, 3, 5);
    set_limits(2047, 0);
    run_phase(250, 40, 35, 20);

    drain();
    if (ledger.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/gha_pkg.sv
src/gha_front.sv
src/gha_back.sv
src/generational_handle_allocator_unit.sv
test/tb.sv
